>>> rtl/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

   localparam int FRAME_W            = 6;
   localparam int CFG_W              = 7;
   localparam int DEFAULT_MAX_FRAMES = 64;
   localparam int REQ_TDATA_W        = 8;
   localparam int RSP_TDATA_W        = 8;

   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 7'd64;

   typedef logic [FRAME_W-1:0] frame_type;

   typedef enum logic {
      ACT_REFERENCE = 1'b0,
      ACT_EVICT     = 1'b1
   } action_type;

   // contents of one recency cell
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } entry_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic      hit_en;
      logic      alloc_en;
      logic      evict_en;
      frame_type frame;
   } ctrl_type;

endpackage

`default_nettype wire

>>> rtl/lru_frame_replacement_top.sv
`default_nettype none

// Exact LRU tracker over page frames, built as a row of MAX_FRAMES cells where
// cell 0 holds the least recently used resident frame. A reference is compared
// against all cells at once and the row closes the gap and appends the frame at
// the most-recent end in the cycle of acceptance; an evict shifts the whole row
// down by one and returns cell 0. The compare-and-shift across the
// cell row allows one transaction per clock while the rsp side keeps up. An
// evict result appears on the rsp side the cycle after acceptance and is held
// in an output register; while that result waits with rsp_tready low,
// req_tready is low and no request of either kind is taken. Out-of-range
// references are dropped without effect.
module lru_frame_replacement_top #(
   parameter int MAX_FRAMES = lfr_pkg::DEFAULT_MAX_FRAMES
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [lfr_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [5:0] frame_index, [7:6] zero
   input  wire  [0:0]                         req_tuser,  // [0] action
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [lfr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [5:0] victim_frame, [7:6] zero
   output logic [0:0]                         rsp_tuser,  // [0] empty_res
   input  wire                                csr_wen,
   input  wire  [lfr_pkg::CFG_W-1:0]          csr_wdata
);
   import lfr_pkg::*;

   logic [CFG_W-1:0]       frames_in_use_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   frame_type              rsp_frame_ff;
   frame_type              rsp_frame_in;
   logic                   rsp_empty_ff;
   logic                   rsp_empty_in;

   logic                   req_accept;
   action_type             req_action;
   frame_type              req_frame;
   logic                   in_range;
   logic                   hit;
   ctrl_type               ctrl;

   entry_type              entry_vec [MAX_FRAMES];
   logic [MAX_FRAMES:0]    shift_vec;
   logic [MAX_FRAMES-1:0]  match_vec;
   logic [MAX_FRAMES-1:0]  valid_vec;

   assign req_action = action_type'(req_tuser[0]);
   assign req_frame  = req_tdata[FRAME_W-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign in_range = ({1'b0, req_frame} < frames_in_use_ff)
                     && (32'(req_frame) < 32'(MAX_FRAMES));
   assign hit      = |match_vec;

   always_comb begin
      ctrl.frame    = req_frame;
      ctrl.evict_en = req_accept && (req_action == ACT_EVICT) && valid_vec[0];
      ctrl.hit_en   = req_accept && (req_action == ACT_REFERENCE) && in_range && hit;
      ctrl.alloc_en = req_accept && (req_action == ACT_REFERENCE) && in_range && !hit
                      && !valid_vec[MAX_FRAMES-1];
   end

   assign shift_vec[0] = 1'b0;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      entry_type next_entry;
      logic      prev_valid;

      if (i == MAX_FRAMES - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = entry_vec[i+1];
      end

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_vec[i-1];
      end

      lfr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid),
         .shift_in   (shift_vec[i]),
         .next_entry (next_entry),
         .entry      (entry_vec[i]),
         .shift_out  (shift_vec[i+1]),
         .match      (match_vec[i])
      );

      assign valid_vec[i] = entry_vec[i].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
      end else if (csr_wen) begin
         frames_in_use_ff <= csr_wdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_empty_in = rsp_empty_ff;
      priority if (req_accept && (req_action == ACT_EVICT)) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = valid_vec[0] ? entry_vec[0].frame : '0;
         rsp_empty_in = !valid_vec[0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff <= rsp_frame_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-FRAME_W){1'b0}}, rsp_frame_ff};
   assign rsp_tuser  = rsp_empty_ff;

   // resident cells always form a contiguous run from the lru end
   a_valid_thermometer: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + {{(MAX_FRAMES-1){1'b0}}, 1'b1})) == '0)
      else $error("resident cells not contiguous");

   // a frame is held by at most one cell
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("frame resident in more than one cell");

   // an evict transaction always yields a result next cycle
   a_evict_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_action == ACT_EVICT) |=> rsp_tvalid
         && (rsp_tuser[0] == !$past(valid_vec[0])))
      else $error("evict result missing or wrong empty flag");

   // an empty result carries frame zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("empty result with nonzero victim");

   // evict removes exactly one resident frame
   a_evict_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.evict_en |=> $countones(valid_vec) + 1 == $countones($past(valid_vec)))
      else $error("evict did not remove one frame");

endmodule

`default_nettype wire

>>> rtl/lfr_cell.sv
`default_nettype none

module lfr_cell (
   input  wire              clock,
   input  wire              reset,
   input  lfr_pkg::ctrl_type  ctrl,
   input  wire              prev_valid,
   input  wire              shift_in,
   input  lfr_pkg::entry_type next_entry,
   output lfr_pkg::entry_type entry,
   output logic             shift_out,
   output logic             match
);
   import lfr_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   frame_type frame_ff;
   frame_type frame_in;
   logic      shift;

   assign match     = valid_ff && (frame_ff == ctrl.frame);
   assign shift     = shift_in || match;
   assign shift_out = shift;
   assign entry     = '{valid: valid_ff, frame: frame_ff};

   always_comb begin
      valid_in = valid_ff;
      frame_in = frame_ff;
      priority if (ctrl.evict_en) begin
         valid_in = next_entry.valid;
         frame_in = next_entry.frame;
      end else if (ctrl.hit_en) begin
         // cells from the hit upward slide down, the top valid one takes the frame
         if (shift) begin
            frame_in = next_entry.valid ? next_entry.frame : ctrl.frame;
         end
      end else if (ctrl.alloc_en) begin
         if (!valid_ff && prev_valid) begin
            valid_in = 1'b1;
            frame_in = ctrl.frame;
         end
      end else begin
         valid_in = valid_ff;
         frame_in = frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lfr_pkg::*;

   localparam int NUM_FRAMES   = DEFAULT_MAX_FRAMES;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      frame_type victim;
      logic      empty;
   } victim_report_t;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [5:0] frame_index, [7:6] zero
   logic [0:0]             req_tuser;   // [0] action
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [5:0] victim_frame, [7:6] zero
   logic [0:0]             rsp_tuser;   // [0] empty_res
   logic                   csr_wen;
   logic [CFG_W-1:0]       csr_wdata;

   // recency stack, entry 0 is least recently used
   frame_type        lru_stack[NUM_FRAMES];
   bit               is_resident[NUM_FRAMES];
   int               resident_total = 0;
   logic [CFG_W-1:0] frames_in_use  = FRAMES_IN_USE_RESET;

   victim_report_t   pending_victims[$];
   int               fail_count       = 0;
   int               idle_cycles      = 0;
   bit               sender_gaps_on   = 1'b1;
   bit               sink_stalls_on   = 1'b1;
   int               sink_hold_cycles = 0;

   lru_frame_replacement_top #(
      .MAX_FRAMES(NUM_FRAMES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int frame_limit();
      return (frames_in_use < NUM_FRAMES) ? int'(frames_in_use) : NUM_FRAMES;
   endfunction

   function automatic void touch_frame(frame_type f);
      int pos;
      if (int'(f) >= frame_limit()) return;
      if (is_resident[f]) begin
         pos = 0;
         while (pos < resident_total && lru_stack[pos] != f) pos++;
         if (pos >= resident_total) return;
         for (int i = pos; i < resident_total - 1; i++) lru_stack[i] = lru_stack[i + 1];
         lru_stack[resident_total - 1] = f;
      end else if (resident_total < NUM_FRAMES) begin
         lru_stack[resident_total] = f;
         is_resident[f] = 1'b1;
         resident_total++;
      end
   endfunction

   function automatic victim_report_t evict_lru();
      victim_report_t r;
      r.victim = '0;
      r.empty  = 1'b1;
      if (resident_total > 0) begin
         r.victim = lru_stack[0];
         r.empty  = 1'b0;
         for (int i = 0; i < resident_total - 1; i++) lru_stack[i] = lru_stack[i + 1];
         resident_total--;
         is_resident[r.victim] = 1'b0;
      end
      return r;
   endfunction

   function automatic frame_type random_frame();
      int lim;
      lim = frame_limit();
      if (lim > 0 && $urandom_range(0, 9) != 0) return frame_type'($urandom_range(0, lim - 1));
      return frame_type'($urandom_range(0, NUM_FRAMES - 1));
   endfunction

   // transaction monitor and checker
   always @(posedge clock) begin : monitor
      victim_report_t got;
      victim_report_t want;
      if (!reset) begin
         if (csr_wen) frames_in_use = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.victim = rsp_tdata[FRAME_W-1:0];
            got.empty  = rsp_tuser[0];
            if (pending_victims.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual victim %0d empty %0d",
                        $time, got.victim, got.empty);
               fail_count++;
            end else begin
               want = pending_victims.pop_front();
               if (got.victim !== want.victim) begin
                  $display("%0t: victim_frame mismatch, expected %0d, actual %0d",
                           $time, want.victim, got.victim);
                  fail_count++;
               end
               if (got.empty !== want.empty) begin
                  $display("%0t: empty_res mismatch, expected %0d, actual %0d",
                           $time, want.empty, got.empty);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (action_type'(req_tuser[0]) == ACT_EVICT) pending_victims.push_back(evict_lru());
            else touch_frame(req_tdata[FRAME_W-1:0]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result sink with random stalls and an optional long hold
   initial begin : sink
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         stall = sink_stalls_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_item(action_type act, frame_type f);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_W - FRAME_W){1'b0}}, f};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_victims.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_frames_in_use(logic [CFG_W-1:0] value);
      drain_pipeline();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic test_empty_evict();
      send_item(ACT_EVICT, frame_type'(NUM_FRAMES - 1));
   endtask

   task automatic test_reference_order();
      send_item(ACT_REFERENCE, frame_type'(0));
      send_item(ACT_REFERENCE, frame_type'(NUM_FRAMES - 1));
      send_item(ACT_REFERENCE, frame_type'(5));
      send_item(ACT_REFERENCE, frame_type'(0));
      repeat (4) send_item(ACT_EVICT, frame_type'(0));
   endtask

   task automatic test_out_of_range();
      set_frames_in_use(7'd10);
      send_item(ACT_REFERENCE, frame_type'(10));
      send_item(ACT_REFERENCE, frame_type'(NUM_FRAMES - 1));
      send_item(ACT_REFERENCE, frame_type'(9));
      repeat (2) send_item(ACT_EVICT, frame_type'(0));
   endtask

   task automatic test_zero_frames();
      set_frames_in_use(7'd0);
      send_item(ACT_REFERENCE, frame_type'(0));
      send_item(ACT_EVICT, frame_type'(0));
   endtask

   task automatic test_oversized_limit();
      set_frames_in_use(7'd127);
      send_item(ACT_REFERENCE, frame_type'(NUM_FRAMES - 1));
      send_item(ACT_EVICT, frame_type'(0));
   endtask

   task automatic test_shrink_limit();
      set_frames_in_use(7'd64);
      send_item(ACT_REFERENCE, frame_type'(40));
      send_item(ACT_REFERENCE, frame_type'(2));
      send_item(ACT_REFERENCE, frame_type'(50));
      set_frames_in_use(7'd10);
      send_item(ACT_REFERENCE, frame_type'(40));
      send_item(ACT_REFERENCE, frame_type'(2));
      repeat (3) send_item(ACT_EVICT, frame_type'(0));
   endtask

   task automatic test_full_stack();
      frame_type order[NUM_FRAMES];
      frame_type tmp;
      int        j;
      set_frames_in_use(7'd64);
      for (int i = 0; i < NUM_FRAMES; i++) order[i] = frame_type'(i);
      for (int i = NUM_FRAMES - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < NUM_FRAMES; i++) send_item(ACT_REFERENCE, order[i]);
      repeat (30) send_item(ACT_REFERENCE, frame_type'($urandom_range(0, NUM_FRAMES - 1)));
      repeat (NUM_FRAMES + 1) send_item(ACT_EVICT, random_frame());
   endtask

   task automatic test_backpressure();
      set_frames_in_use(7'd64);
      sender_gaps_on   = 1'b0;
      sink_hold_cycles = HOLD_CYCLES;
      repeat (10) send_item(ACT_REFERENCE, random_frame());
      repeat (50) send_item(ACT_EVICT, random_frame());
      drain_pipeline();
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int limits[9] = '{64, 127, 1, 2, 17, 0, 40, 65, 64};
      int evict_pct[9] = '{10, 30, 50, 40, 35, 50, 25, 30, 45};
      int mode;
      for (int p = 0; p < 9; p++) begin
         if (p == 8) limits[p] = $urandom_range(1, NUM_FRAMES);
         set_frames_in_use(CFG_W'(limits[p]));
         mode           = p % 4;
         sender_gaps_on = (mode == 0 || mode == 1);
         sink_stalls_on = (mode == 0 || mode == 2);
         repeat (95) begin
            if ($urandom_range(0, 99) < evict_pct[p]) send_item(ACT_EVICT, random_frame());
            else send_item(ACT_REFERENCE, random_frame());
         end
      end
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = FRAMES_IN_USE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_evict();
      test_reference_order();
      test_out_of_range();
      test_zero_frames();
      test_oversized_limit();
      test_shrink_limit();
      test_full_stack();
      test_backpressure();
      test_random_traffic();
      drain_pipeline();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
